// ----- src/gf2_block_sparse_column_engine_assert.svh -----
// ----------------------------------------------------------------------------
// column engine assertion macros
// concurrent checks on the rising clock edge, switched off for synthesis
// ----------------------------------------------------------------------------
`ifndef GF2_BLOCK_SPARSE_COLUMN_ENGINE_ASSERT_SVH
`define GF2_BLOCK_SPARSE_COLUMN_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define GBSC_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gbsc: same-cycle check failed");

// next-cycle implication
`define GBSC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gbsc: next-cycle check failed");

`else

`define GBSC_ASSERT_IMPL(label, ante, cons)
`define GBSC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- src/gbsc_pkg.sv -----
// ----------------------------------------------------------------------------
// gbsc_pkg
// command codes, beat types and shared helpers of the column engine
// ----------------------------------------------------------------------------
package gbsc_pkg;

   localparam int ROW_W = 8;
   localparam int COL_W = 8;
   localparam int MAX_W = 9;

   // command codes
   localparam logic [2:0] CMD_CLEAR  = 3'd0;
   localparam logic [2:0] CMD_APPEND = 3'd1;
   localparam logic [2:0] CMD_ADD    = 3'd2;
   localparam logic [2:0] CMD_QUERY  = 3'd3;
   localparam logic [2:0] CMD_REMOVE = 3'd4;

   // max index of an empty column
   localparam logic signed [MAX_W-1:0] MAX_NONE = -9'sd1;

   typedef struct packed {
      logic [2:0]       command;
      logic [COL_W-1:0] target_col;
      logic [COL_W-1:0] source_col;
      logic [ROW_W-1:0] row_index;
   } req_type;

   typedef struct packed {
      logic signed [MAX_W-1:0] max_index;
      logic                    col_empty;
      logic                    status;
   } rsp_type;

   // divide of an 8-bit value by a constant through a reciprocal multiply
   // recip is ceil(65536 / d), exact for every 8-bit dividend
   // returns {quotient, remainder}
   function automatic logic [15:0] div8(input logic [7:0] v, input int unsigned d,
                                         input int unsigned recip);
      logic [31:0] prod;
      logic [7:0]  q;
      logic [15:0] back;
      prod = 32'(v) * 32'(recip);
      q    = prod[23:16];
      back = 16'(q) * 16'(d);
      return {q, 8'(16'(v) - back)};
   endfunction

endpackage

// ----- src/gbsc_count_ram.sv -----
// ----------------------------------------------------------------------------
// gbsc_count_ram
// per-column block count store, two read ports, one write port, valid bits
// ----------------------------------------------------------------------------
module gbsc_count_ram #(
   parameter int DEPTH = 256,
   parameter int W     = 7,
   parameter int AW    = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [AW-1:0] rd_a_addr,
   input  logic [AW-1:0] rd_b_addr,
   output logic [W-1:0]  rd_a_data,
   output logic [W-1:0]  rd_b_data,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [W-1:0]  wdata
);

   logic [W-1:0]     count_mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [W-1:0]     rd_a_q_ff;
   logic [W-1:0]     rd_b_q_ff;
   logic             rd_a_v_ff;
   logic             rd_b_v_ff;

   // entry valid bits, cleared at once by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (we) begin
         valid_ff[waddr] <= 1'b1;
      end
   end

   // storage write
   always_ff @(posedge clock) begin
      if (we) begin
         count_mem[waddr] <= wdata;
      end
   end

   // registered reads
   always_ff @(posedge clock) begin
      rd_a_q_ff <= count_mem[rd_a_addr];
      rd_b_q_ff <= count_mem[rd_b_addr];
      rd_a_v_ff <= valid_ff[rd_a_addr];
      rd_b_v_ff <= valid_ff[rd_b_addr];
   end

   // an entry never written reads as an empty column
   assign rd_a_data = rd_a_v_ff ? rd_a_q_ff : '0;
   assign rd_b_data = rd_b_v_ff ? rd_b_q_ff : '0;

endmodule

// ----- src/gbsc_block_ram.sv -----
// ----------------------------------------------------------------------------
// gbsc_block_ram
// block position and mask store, two read ports, one write port
// ----------------------------------------------------------------------------
module gbsc_block_ram #(
   parameter int  DEPTH      = 16384,
   parameter int  AW         = 14,
   parameter type entry_type = logic
) (
   input  logic          clock,
   input  logic [AW-1:0] rd_a_addr,
   input  logic [AW-1:0] rd_b_addr,
   output entry_type     rd_a_data,
   output entry_type     rd_b_data,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  entry_type     wdata
);

   entry_type block_mem [DEPTH];
   entry_type rd_a_ff;
   entry_type rd_b_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         block_mem[waddr] <= wdata;
      end
   end

   // registered read ports
   always_ff @(posedge clock) begin
      rd_a_ff <= block_mem[rd_a_addr];
      rd_b_ff <= block_mem[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

// ----- src/gbsc_scratch_ram.sv -----
// ----------------------------------------------------------------------------
// gbsc_scratch_ram
// merge buffer, one read port, one write port
// ----------------------------------------------------------------------------
module gbsc_scratch_ram #(
   parameter int  DEPTH      = 64,
   parameter int  AW         = 6,
   parameter type entry_type = logic
) (
   input  logic          clock,
   input  logic [AW-1:0] raddr,
   output entry_type     rdata,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  entry_type     wdata
);

   entry_type scratch_mem [DEPTH];
   entry_type rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         scratch_mem[waddr] <= wdata;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rdata_ff <= scratch_mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- src/gf2_block_sparse_column_engine.sv -----
// for add, the merge walks both
// lists one block a cycle, then the merged list is copied back one block a cycle
// one command at a time; busy is high from acceptance until the result beat
// the receiver cannot stall: rsp_strobe is high for exactly one cycle per command
// synchronous reset empties every column at once through the count valid bits
// ----------------------------------------------------------------------------
// gf2_block_sparse_column_engine
// block-sparse gf(2) column store with clear, append, add, query and remove
// ----------------------------------------------------------------------------
`include "gf2_block_sparse_column_engine_assert.svh"

module gf2_block_sparse_column_engine #(
   parameter int NUM_COLS       = 256,
   parameter int BITS_PER_BLOCK = 4,
   parameter int MAX_BLOCKS     = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  gbsc_pkg::req_type req_data,
   output logic             rsp_strobe,
   output gbsc_pkg::rsp_type rsp_data
);

   import gbsc_pkg::*;

   localparam int COLS_EFF = (NUM_COLS < 256) ? NUM_COLS : 256;
   localparam int CW       = $clog2(COLS_EFF);
   localparam int CNTW     = $clog2(MAX_BLOCKS + 1);
   localparam int IW       = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int DEPTH    = COLS_EFF * MAX_BLOCKS;
   localparam int AW       = $clog2(DEPTH);
   localparam int POS_MAX  = 255 / BITS_PER_BLOCK;
   localparam int POS_W    = (POS_MAX > 0) ? $clog2(POS_MAX + 1) : 1;
   localparam int TW       = (BITS_PER_BLOCK > 1) ? $clog2(BITS_PER_BLOCK) : 1;
   localparam int COL_RECIP = (65536 + COLS_EFF - 1) / COLS_EFF;
   localparam int ROW_RECIP = (65536 + BITS_PER_BLOCK - 1) / BITS_PER_BLOCK;

   // sequencer states
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_CNT_USE  = 4'd1;
   localparam logic [3:0] S_MRG_HEAD = 4'd2;
   localparam logic [3:0] S_MRG      = 4'd3;
   localparam logic [3:0] S_CP       = 4'd4;
   localparam logic [3:0] S_LAST_RD  = 4'd5;
   localparam logic [3:0] S_LAST_USE = 4'd6;

   typedef struct packed {
      logic [POS_W-1:0]          pos;
      logic [BITS_PER_BLOCK-1:0] mask;
   } entry_type;

   // highest set bit of a block mask
   function automatic logic [TW-1:0] top_bit(input logic [BITS_PER_BLOCK-1:0] m);
      logic [TW-1:0] b;
      b = '0;
      for (int k = 0; k < BITS_PER_BLOCK; k++) begin
         if (m[k]) begin
            b = TW'(k);
         end
      end
      return b;
   endfunction

   logic [3:0]                state_ff, state_in;
   logic [2:0]                cmd_ff, cmd_in;
   logic [CW-1:0]             t_ff, t_in;
   logic [CW-1:0]             s_ff, s_in;
   logic [ROW_W-1:0]          row_ff, row_in;
   logic [POS_W-1:0]          rowq_ff, rowq_in;
   logic [TW-1:0]             rowr_ff, rowr_in;
   logic [CNTW-1:0]           ct_ff, ct_in;
   logic [CNTW-1:0]           cs_ff, cs_in;
   logic                      status_ff, status_in;
   logic [CNTW-1:0]           i_ff, i_in;
   logic [CNTW-1:0]           j_ff, j_in;
   logic [CNTW-1:0]           n_ff, n_in;
   entry_type                 ht_ff, ht_in;
   entry_type                 hs_ff, hs_in;
   logic [CNTW-1:0]           cp_k_ff, cp_k_in;
   logic                      cp_wv_ff, cp_wv_in;
   logic [IW-1:0]             cp_wk_ff, cp_wk_in;
   logic                      rsp_strobe_ff, rsp_strobe_in;
   rsp_type                   rsp_ff, rsp_in;

   logic                      accept;
   logic [15:0]               t_div, s_div, row_div;
   logic [CW-1:0]             t_mod, s_mod;
   logic [AW-1:0]             base_t, base_s, last_addr;

   logic [CNTW-1:0]           cnt_a, cnt_b;
   logic                      cnt_we;
   logic [CW-1:0]             cnt_waddr;
   logic [CNTW-1:0]           cnt_wdata;

   logic [AW-1:0]             blk_ra_addr, blk_rb_addr, blk_waddr;
   entry_type                 blk_ra_data, blk_rb_data, blk_wdata;
   logic                      blk_we;

   logic [IW-1:0]             scr_raddr, scr_waddr;
   entry_type                 scr_rdata, scr_wdata;
   logic                      scr_we;

   logic                      va, vb, same, advi, advj, keep;
   entry_type                 pick;
   logic [TW-1:0]             last_tb;
   logic [MAX_W-1:0]          last_max;
   logic [BITS_PER_BLOCK-1:0] row_bit, rem_mask;

   // command acceptance and column folding
   assign accept  = start && !busy;
   assign busy    = (state_ff != S_IDLE);
   assign t_div   = div8(req_data.target_col, COLS_EFF, COL_RECIP);
   assign s_div   = div8(req_data.source_col, COLS_EFF, COL_RECIP);
   assign row_div = div8(req_data.row_index, BITS_PER_BLOCK, ROW_RECIP);
   assign t_mod   = CW'(t_div[7:0]);
   assign s_mod   = CW'(s_div[7:0]);

   // column base addresses in the block store
   assign base_t    = AW'(int'(t_ff) * MAX_BLOCKS);
   assign base_s    = AW'(int'(s_ff) * MAX_BLOCKS);
   assign last_addr = AW'(int'(base_t) + int'(ct_ff) - 1);

   // last block of the target, as read back
   assign last_tb  = top_bit(blk_ra_data.mask);
   assign last_max = MAX_W'(int'(blk_ra_data.pos) * BITS_PER_BLOCK + int'(last_tb));
   assign row_bit  = BITS_PER_BLOCK'(1) << rowr_ff;
   assign rem_mask = blk_ra_data.mask ^ (BITS_PER_BLOCK'(1) << last_tb);

   // merge step decision on the two head blocks
   assign va   = (i_ff < ct_ff);
   assign vb   = (j_ff < cs_ff);
   assign same = va && vb && (ht_ff.pos == hs_ff.pos);

   always_comb begin
      advi = 1'b0;
      advj = 1'b0;
      pick = ht_ff;
      keep = 1'b1;
      if (same) begin
         advi      = 1'b1;
         advj      = 1'b1;
         pick.mask = ht_ff.mask ^ hs_ff.mask;
         keep      = |pick.mask;
      end else if (!vb || (va && (ht_ff.pos < hs_ff.pos))) begin
         advi = 1'b1;
      end else begin
         advj = 1'b1;
         pick = hs_ff;
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      t_in          = t_ff;
      s_in          = s_ff;
      row_in        = row_ff;
      rowq_in       = rowq_ff;
      rowr_in       = rowr_ff;
      ct_in         = ct_ff;
      cs_in         = cs_ff;
      status_in     = status_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      n_in          = n_ff;
      ht_in         = ht_ff;
      hs_in         = hs_ff;
      cp_k_in       = cp_k_ff;
      cp_wv_in      = 1'b0;
      cp_wk_in      = cp_wk_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;

      cnt_we        = 1'b0;
      cnt_waddr     = t_ff;
      cnt_wdata     = '0;
      blk_ra_addr   = last_addr;
      blk_rb_addr   = base_s;
      blk_we        = 1'b0;
      blk_waddr     = last_addr;
      blk_wdata     = blk_ra_data;
      scr_raddr     = cp_k_ff[IW-1:0];
      scr_we        = 1'b0;
      scr_waddr     = n_ff[IW-1:0];
      scr_wdata     = pick;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in    = (req_data.command > CMD_REMOVE) ? CMD_QUERY : req_data.command;
               t_in      = t_mod;
               s_in      = s_mod;
               row_in    = req_data.row_index;
               rowq_in   = POS_W'(row_div[15:8]);
               rowr_in   = TW'(row_div[7:0]);
               status_in = 1'b0;
               state_in  = S_CNT_USE;
            end
         end

         S_CNT_USE: begin
            ct_in = cnt_a;
            cs_in = cnt_b;
            i_in  = '0;
            j_in  = '0;
            n_in  = '0;
            unique case (cmd_ff)
               CMD_CLEAR: begin
                  cnt_we   = 1'b1;
                  ct_in    = '0;
                  cmd_in   = CMD_QUERY;
                  state_in = S_LAST_RD;
               end
               CMD_ADD: begin
                  blk_ra_addr = base_t;
                  blk_rb_addr = base_s;
                  state_in    = S_MRG_HEAD;
               end
               default: begin
                  state_in = S_LAST_RD;
               end
            endcase
         end

         // first blocks arrive, prefetch the second ones
         S_MRG_HEAD: begin
            ht_in       = blk_ra_data;
            hs_in       = blk_rb_data;
            blk_ra_addr = AW'(int'(base_t) + 1);
            blk_rb_addr = AW'(int'(base_s) + 1);
            state_in    = S_MRG;
         end

         // at most one output block per cycle, read ports run one ahead of the heads
         S_MRG: begin
            if (!va && !vb) begin
               cp_k_in  = '0;
               state_in = S_CP;
            end else begin
               if (advi) begin
                  ht_in = blk_ra_data;
                  i_in  = CNTW'(int'(i_ff) + 1);
               end
               if (advj) begin
                  hs_in = blk_rb_data;
                  j_in  = CNTW'(int'(j_ff) + 1);
               end
               blk_ra_addr = AW'(int'(base_t) + int'(i_ff) + (advi ? 2 : 1));
               blk_rb_addr = AW'(int'(base_s) + int'(j_ff) + (advj ? 2 : 1));
               if (keep && (int'(n_ff) < MAX_BLOCKS)) begin
                  scr_we = 1'b1;
                  n_in   = CNTW'(int'(n_ff) + 1);
               end
            end
         end

         // copy the merged list back over the target
         S_CP: begin
            if (cp_k_ff < n_ff) begin
               cp_wv_in = 1'b1;
               cp_wk_in = cp_k_ff[IW-1:0];
               cp_k_in  = CNTW'(int'(cp_k_ff) + 1);
            end
            if (cp_wv_ff) begin
               blk_we    = 1'b1;
               blk_waddr = AW'(int'(base_t) + int'(cp_wk_ff));
               blk_wdata = scr_rdata;
            end else if (cp_k_ff == n_ff) begin
               cnt_we    = 1'b1;
               cnt_wdata = n_ff;
               ct_in     = n_ff;
               cmd_in    = CMD_QUERY;
               state_in  = S_LAST_RD;
            end
         end

         S_LAST_RD: begin
            blk_ra_addr = last_addr;
            state_in    = S_LAST_USE;
         end

         S_LAST_USE: begin
            rsp_in.max_index = (ct_ff == '0) ? MAX_NONE : signed'(last_max);
            rsp_in.col_empty = (ct_ff == '0);
            rsp_in.status    = status_ff;
            unique case (cmd_ff)
               CMD_APPEND: begin
                  if ((ct_ff != '0) && (int'(row_ff) <= int'(last_max))) begin
                     rsp_in.status = 1'b1;
                     rsp_strobe_in = 1'b1;
                     state_in      = S_IDLE;
                  end else if ((ct_ff != '0) && (blk_ra_data.pos == rowq_ff)) begin
                     blk_we         = 1'b1;
                     blk_wdata.mask = blk_ra_data.mask | row_bit;
                     cmd_in         = CMD_QUERY;
                     state_in       = S_LAST_RD;
                  end else if (int'(ct_ff) >= MAX_BLOCKS) begin
                     rsp_in.status = 1'b1;
                     rsp_strobe_in = 1'b1;
                     state_in      = S_IDLE;
                  end else begin
                     blk_we         = 1'b1;
                     blk_waddr      = AW'(int'(base_t) + int'(ct_ff));
                     blk_wdata.pos  = rowq_ff;
                     blk_wdata.mask = row_bit;
                     cnt_we         = 1'b1;
                     cnt_wdata      = CNTW'(int'(ct_ff) + 1);
                     ct_in          = CNTW'(int'(ct_ff) + 1);
                     cmd_in         = CMD_QUERY;
                     state_in       = S_LAST_RD;
                  end
               end
               CMD_REMOVE: begin
                  if (ct_ff == '0) begin
                     rsp_strobe_in = 1'b1;
                     state_in      = S_IDLE;
                  end else begin
                     blk_we         = 1'b1;
                     blk_wdata.mask = rem_mask;
                     if (rem_mask == '0) begin
                        cnt_we    = 1'b1;
                        cnt_wdata = CNTW'(int'(ct_ff) - 1);
                        ct_in     = CNTW'(int'(ct_ff) - 1);
                     end
                     cmd_in   = CMD_QUERY;
                     state_in = S_LAST_RD;
                  end
               end
               default: begin
                  rsp_strobe_in = 1'b1;
                  state_in      = S_IDLE;
               end
            endcase
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
         cp_wv_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         cp_wv_ff      <= cp_wv_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      t_ff      <= t_in;
      s_ff      <= s_in;
      row_ff    <= row_in;
      rowq_ff   <= rowq_in;
      rowr_ff   <= rowr_in;
      ct_ff     <= ct_in;
      cs_ff     <= cs_in;
      status_ff <= status_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      n_ff      <= n_in;
      ht_ff     <= ht_in;
      hs_ff     <= hs_in;
      cp_k_ff   <= cp_k_in;
      cp_wk_ff  <= cp_wk_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // count store, read at acceptance for target and source
   gbsc_count_ram #(
      .DEPTH (COLS_EFF),
      .W     (CNTW),
      .AW    (CW)
   ) u_count (
      .clock     (clock),
      .reset     (reset),
      .rd_a_addr (t_mod),
      .rd_b_addr (s_mod),
      .rd_a_data (cnt_a),
      .rd_b_data (cnt_b),
      .we        (cnt_we),
      .waddr     (cnt_waddr),
      .wdata     (cnt_wdata)
   );

   gbsc_block_ram #(
      .DEPTH      (DEPTH),
      .AW         (AW),
      .entry_type (entry_type)
   ) u_block (
      .clock     (clock),
      .rd_a_addr (blk_ra_addr),
      .rd_b_addr (blk_rb_addr),
      .rd_a_data (blk_ra_data),
      .rd_b_data (blk_rb_data),
      .we        (blk_we),
      .waddr     (blk_waddr),
      .wdata     (blk_wdata)
   );

   gbsc_scratch_ram #(
      .DEPTH      (MAX_BLOCKS),
      .AW         (IW),
      .entry_type (entry_type)
   ) u_scratch (
      .clock (clock),
      .raddr (scr_raddr),
      .rdata (scr_rdata),
      .we    (scr_we),
      .waddr (scr_waddr),
      .wdata (scr_wdata)
   );

   // checks
   `GBSC_ASSERT_NEXT(a_accept_busy, accept, busy)
   `GBSC_ASSERT_IMPL(a_rsp_idle, rsp_strobe, !busy)
   `GBSC_ASSERT_IMPL(a_merge_bound, state_ff == S_MRG, int'(n_ff) <= MAX_BLOCKS)
   `GBSC_ASSERT_IMPL(a_empty_max, rsp_strobe && rsp_data.col_empty, rsp_data.max_index == MAX_NONE)

endmodule

// ----- test/tb_gf2_block_sparse_column_engine.sv -----
// ----------------------------------------------------------------------------
// tb_gf2_block_sparse_column_engine
// drives clear, append, add, query and remove commands into the column engine,
// mirrors the column store in a behavioural model and checks every result beat
// ----------------------------------------------------------------------------
module tb_gf2_block_sparse_column_engine;
   timeunit 1ns;
   timeprecision 1ps;

   import gbsc_pkg::*;

   localparam int NCOLS      = 256;
   localparam int BLK_BITS   = 4;
   localparam int BLK_LIMIT  = 64;
   localparam int RAND_BEATS = 1000;
   localparam int IDLE_LIMIT = 20000;
   localparam int DRAIN_WAIT = 250;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   gf2_block_sparse_column_engine DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   // model of the column store
   int        col_len [NCOLS];
   logic [5:0] col_pos [NCOLS][BLK_LIMIT];
   logic [3:0] col_bits[NCOLS][BLK_LIMIT];

   rsp_type   result_queue[$];
   int        error_count;
   int        idle_cycles;
   bit        timed_out;

   // directed stimulus, with typed-in answers where obvious
   typedef struct {
      req_type cmd;
      bit      known;
      rsp_type answer;
   } row_type;

   function automatic int msb4(logic [3:0] m);
      int b;
      b = 0;
      for (int k = 0; k < 4; k++)
         if (m[k]) b = k;
      return b;
   endfunction

   function automatic logic signed [8:0] highest_row(int c);
      int n;
      n = col_len[c];
      if (n == 0) return MAX_NONE;
      return 9'(col_pos[c][n-1] * BLK_BITS + msb4(col_bits[c][n-1]));
   endfunction

   // apply one command to the model and return the expected beat
   function automatic rsp_type column_update(req_type r);
      rsp_type    o;
      int         t, s, n, i, j, m;
      int         pos;
      logic [3:0] bit1, x;
      logic [5:0] mp[BLK_LIMIT];
      logic [3:0] mm[BLK_LIMIT];
      logic [5:0] p;
      t = r.target_col;
      s = r.source_col;
      o.status = 1'b0;
      case (r.command)
         CMD_CLEAR: col_len[t] = 0;
         CMD_APPEND: begin
            n = col_len[t];
            pos = r.row_index / BLK_BITS;
            bit1 = 4'b1 << (r.row_index % BLK_BITS);
            if (n != 0 && $signed({1'b0, r.row_index}) <= highest_row(t))
               o.status = 1'b1;
            else if (n != 0 && col_pos[t][n-1] == pos)
               col_bits[t][n-1] |= bit1;
            else if (n >= BLK_LIMIT)
               o.status = 1'b1;
            else begin
               col_pos[t][n] = 6'(pos);
               col_bits[t][n] = bit1;
               col_len[t] = n + 1;
            end
         end
         CMD_ADD: begin
            i = 0; j = 0; m = 0;
            while (i < col_len[t] || j < col_len[s]) begin
               if (i < col_len[t] && j < col_len[s] && col_pos[t][i] == col_pos[s][j]) begin
                  p = col_pos[t][i];
                  x = col_bits[t][i] ^ col_bits[s][j];
                  i++; j++;
               end else if (j >= col_len[s] ||
                            (i < col_len[t] && col_pos[t][i] < col_pos[s][j])) begin
                  p = col_pos[t][i]; x = col_bits[t][i]; i++;
               end else begin
                  p = col_pos[s][j]; x = col_bits[s][j]; j++;
               end
               if (x != 0 && m < BLK_LIMIT) begin
                  mp[m] = p; mm[m] = x; m++;
               end
            end
            for (int k = 0; k < m; k++) begin
               col_pos[t][k] = mp[k];
               col_bits[t][k] = mm[k];
            end
            col_len[t] = m;
         end
         CMD_REMOVE: begin
            n = col_len[t];
            if (n != 0) begin
               col_bits[t][n-1][msb4(col_bits[t][n-1])] = 1'b0;
               if (col_bits[t][n-1] == 0) col_len[t] = n - 1;
            end
         end
         default: ;
      endcase
      o.max_index = highest_row(t);
      o.col_empty = (col_len[t] == 0);
      return o;
   endfunction

   function automatic req_type make_cmd(logic [2:0] c, logic [7:0] t, logic [7:0] s,
                                        logic [7:0] r);
      req_type q;
      q.command = c; q.target_col = t; q.source_col = s; q.row_index = r;
      return q;
   endfunction

   function automatic rsp_type make_rsp(logic signed [8:0] mx, logic e, logic st);
      rsp_type q;
      q.max_index = mx; q.col_empty = e; q.status = st;
      return q;
   endfunction

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // issue one command beat, waiting for the block to take it
   task automatic send_beat(req_type r, bit known, rsp_type answer);
      rsp_type exp_rsp;
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      exp_rsp = column_update(r);
      if (known && exp_rsp !== answer) begin
         $display("%0t typed-in answer %p disagrees with model %p", $time, answer, exp_rsp);
         error_count++;
      end
      // typed-in rows are checked against the typed answer
      result_queue.push_back(known ? answer : exp_rsp);
      @(negedge clock);
   endtask

   task automatic go_idle(int n);
      if (n > 0) begin
         start <= 1'b0;
         req_data <= make_cmd(3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
         repeat (n) @(negedge clock);
      end
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (result_queue.size() == 0) begin
            $display("%0t unexpected result beat: expected none, actual %p", $time, rsp_data);
            error_count++;
         end else begin
            rsp_type want;
            want = result_queue.pop_front();
            if (rsp_data.max_index !== want.max_index ||
                rsp_data.col_empty !== want.col_empty ||
                rsp_data.status !== want.status) begin
               $display("%0t result mismatch: expected %p, actual %p", $time, want, rsp_data);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles with nothing accepted
   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("TEST FAILED");
         $finish;
      end
   end

   // random command with biased columns and rows
   function automatic req_type random_cmd();
      logic [2:0] c;
      logic [7:0] t, s, r;
      int k;
      k = $urandom_range(0, 99);
      if (k < 40) c = CMD_APPEND;
      else if (k < 60) c = CMD_ADD;
      else if (k < 72) c = CMD_REMOVE;
      else if (k < 82) c = CMD_QUERY;
      else if (k < 88) c = CMD_CLEAR;
      else c = 3'($urandom_range(0, 7));
      t = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 7)) : 8'($urandom);
      s = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 7)) : 8'($urandom);
      if (c == CMD_APPEND && $urandom_range(0, 9) < 8) begin
         r = 8'(int'(highest_row(t)) + 1 + $urandom_range(0, 12));
         if (highest_row(t) >= 9'sd243) r = 8'($urandom);
      end else r = 8'($urandom);
      return make_cmd(c, t, s, r);
   endfunction

   initial begin
      row_type script[$];
      rsp_type none;
      int burst;
      none = '0;
      error_count = 0;
      idle_cycles = 0;
      timed_out = 1'b0;
      for (int c = 0; c < NCOLS; c++) col_len[c] = 0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;

      // directed table
      script.push_back('{make_cmd(CMD_QUERY, 8'd0, 8'd0, 8'd0), 1, make_rsp(MAX_NONE, 1, 0)});
      script.push_back('{make_cmd(CMD_QUERY, 8'd255, 8'd0, 8'd0), 1, make_rsp(MAX_NONE, 1, 0)});
      script.push_back('{make_cmd(CMD_REMOVE, 8'd1, 8'd0, 8'd0), 1, make_rsp(MAX_NONE, 1, 0)});
      script.push_back('{make_cmd(CMD_APPEND, 8'd1, 8'd0, 8'd0), 1, make_rsp(9'sd0, 0, 0)});
      script.push_back('{make_cmd(CMD_APPEND, 8'd1, 8'd0, 8'd0), 1, make_rsp(9'sd0, 0, 1)});
      script.push_back('{make_cmd(CMD_APPEND, 8'd1, 8'd0, 8'd3), 1, make_rsp(9'sd3, 0, 0)});
      script.push_back('{make_cmd(CMD_APPEND, 8'd1, 8'd0, 8'd255), 1, make_rsp(9'sd255, 0, 0)});
      script.push_back('{make_cmd(CMD_APPEND, 8'd1, 8'd0, 8'd100), 1, make_rsp(9'sd255, 0, 1)});
      script.push_back('{make_cmd(CMD_APPEND, 8'd2, 8'd0, 8'd3), 1, make_rsp(9'sd3, 0, 0)});
      script.push_back('{make_cmd(CMD_APPEND, 8'd2, 8'd0, 8'd170), 1, make_rsp(9'sd170, 0, 0)});
      script.push_back('{make_cmd(CMD_ADD, 8'd2, 8'd1, 8'd0), 0, none});
      script.push_back('{make_cmd(CMD_ADD, 8'd3, 8'd2, 8'd85), 0, none});
      script.push_back('{make_cmd(CMD_ADD, 8'd3, 8'd3, 8'd0), 1, make_rsp(MAX_NONE, 1, 0)});
      script.push_back('{make_cmd(CMD_REMOVE, 8'd1, 8'd0, 8'd0), 1, make_rsp(9'sd3, 0, 0)});
      script.push_back('{make_cmd(CMD_REMOVE, 8'd1, 8'd0, 8'd0), 1, make_rsp(9'sd0, 0, 0)});
      script.push_back('{make_cmd(3'd5, 8'd2, 8'd0, 8'd0), 0, none});
      script.push_back('{make_cmd(3'd6, 8'd2, 8'd255, 8'd255), 0, none});
      script.push_back('{make_cmd(3'd7, 8'd1, 8'd0, 8'd0), 1, make_rsp(9'sd0, 0, 0)});
      script.push_back('{make_cmd(CMD_CLEAR, 8'd1, 8'd0, 8'd0), 1, make_rsp(MAX_NONE, 1, 0)});
      script.push_back('{make_cmd(CMD_ADD, 8'd255, 8'd2, 8'd0), 0, none});

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (script[i]) send_beat(script[i].cmd, script[i].known, script[i].answer);

      // fill column 4 completely: 64 blocks, then an append into the last block
      for (int b = 0; b < BLK_LIMIT; b++)
         send_beat(make_cmd(CMD_APPEND, 8'd4, 8'd0, 8'(b * 4)), 0, none);
      send_beat(make_cmd(CMD_APPEND, 8'd4, 8'd0, 8'd255), 1, make_rsp(9'sd255, 0, 0));
      // odd rows in column 5 then add: every block position matches, so all 64 blocks stay
      for (int b = 0; b < BLK_LIMIT; b++)
         send_beat(make_cmd(CMD_APPEND, 8'd5, 8'd0, 8'(b * 4 + 1)), 0, none);
      send_beat(make_cmd(CMD_ADD, 8'd4, 8'd5, 8'd0), 0, none);
      send_beat(make_cmd(CMD_ADD, 8'd6, 8'd4, 8'd0), 0, none);

      // hold off until everything has come back
      go_idle(1);
      while (result_queue.size() != 0) @(negedge clock);

      // random bursts
      for (int n = 0; n < RAND_BEATS; ) begin
         burst = ($urandom_range(0, 3) == 0) ? 30 : $urandom_range(1, 8);
         for (int b = 0; b < burst && n < RAND_BEATS; b++, n++)
            send_beat(random_cmd(), 0, none);
         go_idle($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 12));
      end

      go_idle(1);
      while (result_queue.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);

      if (error_count == 0 && result_queue.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
